FILE: hw/rtl/bbn_pkg.sv
// Shared types, widths and codes of the bevelled box edge normal block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package bbn_pkg;

	// Fraction bits of the rotation and normal format.
	localparam int ROT_FRAC_BITS = 14;
	localparam int ONE           = 1 << ROT_FRAC_BITS;

	// Datapath widths.
	localparam int D_W      = 33;                      // point minus offset
	localparam int PROD_W   = D_W + 16;                // rotation entry times offset
	localparam int ACC_W    = PROD_W + 2;              // sum of three products
	localparam int Q_W      = ACC_W - ROT_FRAC_BITS;   // body frame coordinate
	localparam int DM_W     = Q_W + 1;                 // distance to shrunk box
	localparam int A_W      = DM_W;                    // magnitude per axis
	localparam int LZ_W     = $clog2(A_W + 1);
	localparam int NRM_W    = 24;                      // normalised magnitude
	localparam int SQ_W     = 2 * NRM_W;
	localparam int S_W      = SQ_W + 2;
	localparam int SQ_STEPS = (S_W + 12) / 2;          // root bits
	localparam int X_W      = 2 * SQ_STEPS;
	localparam int L_W      = SQ_STEPS;
	localparam int QT_W     = 16;                      // quotient bits
	localparam int NUM_SH   = ROT_FRAC_BITS + 6;
	localparam int NUM_W    = NRM_W + NUM_SH + 1;
	localparam int U_W      = 16;
	localparam int UP_W     = 32;
	localparam int UACC_W   = UP_W + 2;
	localparam int W_W      = UACC_W - ROT_FRAC_BITS;

	// Result status codes.
	localparam logic [1:0] ST_NONE  = 2'd0;
	localparam logic [1:0] ST_VALID = 2'd1;
	localparam logic [1:0] ST_ZERO  = 2'd2;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_MIN_X = 3'd0;
	localparam logic [2:0] REG_MIN_Y = 3'd1;
	localparam logic [2:0] REG_MIN_Z = 3'd2;
	localparam logic [2:0] REG_MAX_X = 3'd3;
	localparam logic [2:0] REG_MAX_Y = 3'd4;
	localparam logic [2:0] REG_MAX_Z = 3'd5;
	localparam logic [2:0] REG_BEVEL = 3'd6;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic signed [31:0] body_offset_x;
		logic signed [31:0] body_offset_y;
		logic signed [31:0] body_offset_z;
		logic [47:0]        rot_row_a;
		logic [47:0]        rot_row_b;
		logic [47:0]        rot_row_c;
	} in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
	} out_t;

	// Side information that travels with a word down the pipeline.
	typedef struct packed {
		logic [2:0][2:0][15:0] rm;     // rm[row][col]
		logic [2:0]            neg;    // axis sign is negative
		logic [1:0]            status;
	} tag_t;

	typedef struct packed {
		tag_t                  tag;
		logic [2:0][NRM_W-1:0] an;
	} sq_pass_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bbn_xform.sv
// World to body frame transform: subtract, multiply by R transposed, sum and round.
// Depends on bbn_pkg.
`default_nettype none

module bbn_xform (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 en,
	input  wire                 vin,
	input  bbn_pkg::in_t        din,
	output logic                vout,
	output logic [2:0][bbn_pkg::Q_W-1:0] qout,
	output bbn_pkg::tag_t       tag_out
);
	import bbn_pkg::*;

	logic [2:0] v_q;
	logic signed [D_W-1:0]    d_s1 [3];
	tag_t                     tag_s1, tag_s2, tag_s3;
	logic signed [PROD_W-1:0] prod_s2 [3][3];
	logic [2:0][Q_W-1:0]      q_s3;
	logic signed [D_W-1:0]    d_c [3];
	logic signed [ACC_W-1:0]  acc_c [3];
	tag_t                     tag_c;

	always_comb begin
		d_c[0] = D_W'(din.point_x) - D_W'(din.body_offset_x);
		d_c[1] = D_W'(din.point_y) - D_W'(din.body_offset_y);
		d_c[2] = D_W'(din.point_z) - D_W'(din.body_offset_z);
		tag_c.rm[0] = din.rot_row_a;
		tag_c.rm[1] = din.rot_row_b;
		tag_c.rm[2] = din.rot_row_c;
		tag_c.neg = '0;
		tag_c.status = ST_NONE;
		for (int j = 0; j < 3; j++) begin
			acc_c[j] = ACC_W'(prod_s2[0][j]) + ACC_W'(prod_s2[1][j]) + ACC_W'(prod_s2[2][j])
				+ ACC_W'(1 << (ROT_FRAC_BITS - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[1:0], vin};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1   <= d_c;
			tag_s1 <= tag_c;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s2[i][j] <= PROD_W'($signed(tag_s1.rm[i][j])) * PROD_W'(d_s1[i]);
				end
			end
			for (int j = 0; j < 3; j++) begin
				q_s3[j] <= Q_W'(acc_c[j] >>> ROT_FRAC_BITS);
			end
		end
	end

	assign vout    = v_q[2];
	assign qout    = q_s3;
	assign tag_out = tag_s3;

endmodule

`default_nettype wire

FILE: hw/rtl/bbn_shape.sv
// Edge classification, magnitude normalisation and sum of squares.
// Depends on bbn_pkg.
`default_nettype none

module bbn_shape (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          en,
	input  wire                          vin,
	input  wire [2:0][bbn_pkg::Q_W-1:0]  qin,
	input  bbn_pkg::tag_t                tag_in,
	input  wire [2:0][31:0]              box_lo,
	input  wire [2:0][31:0]              box_hi,
	input  wire [30:0]                   bevel,
	output logic                         vout,
	output logic [bbn_pkg::S_W-1:0]      sum_out,
	output bbn_pkg::sq_pass_t            pass_out
);
	import bbn_pkg::*;

	logic [6:0] v_q;
	logic signed [DM_W-1:0] dmax_s1 [3];
	logic signed [DM_W-1:0] dmin_s1 [3];
	tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7;
	logic [A_W-1:0]   a_s2 [3];
	logic [A_W-1:0]   a_s3 [3];
	logic [A_W-1:0]   mx_s3;
	logic [A_W-1:0]   a_s4 [3];
	logic [LZ_W-1:0]  lz_s4;
	logic [2:0][NRM_W-1:0] an_s5, an_s6, an_s7;
	logic [SQ_W-1:0]  sq_s6 [3];
	logic [S_W-1:0]   sum_s7;

	logic signed [DM_W:0] mag_c [3];
	logic [A_W-1:0]   a_c [3];
	logic [2:0]       nz_c, neg_c;
	logic [A_W-1:0]   mx_c;
	logic [LZ_W-1:0]  lz_c;
	logic             found_c;
	logic [A_W-1:0]   sh_c [3];
	logic signed [DM_W-1:0] r_c;
	tag_t             tag2_c, tag3_c;

	always_comb begin
		r_c = DM_W'($signed({1'b0, bevel}));
		for (int j = 0; j < 3; j++) begin
			nz_c[j]  = (!dmax_s1[j][DM_W-1]) ^ (dmin_s1[j][DM_W-1] || dmin_s1[j] == '0);
			neg_c[j] = (dmin_s1[j][DM_W-1] || dmin_s1[j] == '0) && dmax_s1[j][DM_W-1];
			if ((DM_W+1)'(dmax_s1[j]) > -((DM_W+1)'(dmin_s1[j]))) begin
				mag_c[j] = (DM_W+1)'(dmax_s1[j]);
			end else begin
				mag_c[j] = -((DM_W+1)'(dmin_s1[j]));
			end
			a_c[j] = (nz_c[j] && mag_c[j] > 0) ? A_W'(mag_c[j]) : '0;
		end
		mx_c = a_s2[0];
		if (a_s2[1] > mx_c) mx_c = a_s2[1];
		if (a_s2[2] > mx_c) mx_c = a_s2[2];

		// Two or more axes in the rounded zone make an edge or a corner.
		tag2_c = tag_s1;
		tag2_c.neg = neg_c;
		tag2_c.status = ($countones(nz_c) >= 2) ? ST_VALID : ST_NONE;

		tag3_c = tag_s2;
		if (tag_s2.status == ST_VALID && mx_c == '0) begin
			tag3_c.status = ST_ZERO;
		end

		lz_c = '0;
		found_c = 1'b0;
		for (int b = A_W - 1; b >= 0; b--) begin
			if (!found_c && mx_s3[b]) begin
				lz_c = LZ_W'(A_W - 1 - b);
				found_c = 1'b1;
			end
		end
		for (int j = 0; j < 3; j++) begin
			sh_c[j] = a_s4[j] << lz_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[5:0], vin};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				dmax_s1[j] <= DM_W'($signed(qin[j])) - DM_W'($signed(box_hi[j])) + r_c;
				dmin_s1[j] <= DM_W'($signed(qin[j])) - DM_W'($signed(box_lo[j])) - r_c;
			end
			tag_s1 <= tag_in;

			a_s2 <= a_c;
			tag_s2 <= tag2_c;

			a_s3 <= a_s2;
			mx_s3 <= mx_c;
			tag_s3 <= tag3_c;

			a_s4 <= a_s3;
			lz_s4 <= lz_c;
			tag_s4 <= tag_s3;

			for (int j = 0; j < 3; j++) begin
				an_s5[j] <= sh_c[j][A_W-1 -: NRM_W];
			end
			tag_s5 <= tag_s4;

			for (int j = 0; j < 3; j++) begin
				sq_s6[j] <= SQ_W'(an_s5[j]) * SQ_W'(an_s5[j]);
			end
			an_s6 <= an_s5;
			tag_s6 <= tag_s5;

			sum_s7 <= S_W'(sq_s6[0]) + S_W'(sq_s6[1]) + S_W'(sq_s6[2]);
			an_s7 <= an_s6;
			tag_s7 <= tag_s6;
		end
	end

	assign vout         = v_q[6];
	assign sum_out      = sum_s7;
	assign pass_out.tag = tag_s7;
	assign pass_out.an  = an_s7;

endmodule

`default_nettype wire

FILE: hw/rtl/bbn_sqrt.sv
// Pipelined integer square root, one root bit per stage, of the sum of squares.
// Depends on bbn_pkg.
`default_nettype none

module bbn_sqrt (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        en,
	input  wire                        vin,
	input  wire [bbn_pkg::S_W-1:0]     sum_in,
	input  bbn_pkg::sq_pass_t          pass_in,
	output logic                       vout,
	output logic [bbn_pkg::L_W-1:0]    root_out,
	output bbn_pkg::sq_pass_t          pass_out
);
	import bbn_pkg::*;

	logic [SQ_STEPS-1:0] v_q;
	logic [X_W-1:0]  x_s    [SQ_STEPS];
	logic [L_W+1:0]  rem_s  [SQ_STEPS];
	logic [L_W-1:0]  root_s [SQ_STEPS];
	sq_pass_t        pass_s [SQ_STEPS];

	logic [X_W-1:0]  x_c    [SQ_STEPS];
	logic [L_W+1:0]  rem_c  [SQ_STEPS];
	logic [L_W-1:0]  root_c [SQ_STEPS];
	logic [L_W+3:0]  r2_c   [SQ_STEPS];
	logic [L_W+3:0]  trial_c[SQ_STEPS];
	logic            ge_c   [SQ_STEPS];

	always_comb begin
		x_c[0]    = {sum_in, 12'b0};
		rem_c[0]  = '0;
		root_c[0] = '0;
		for (int k = 1; k < SQ_STEPS; k++) begin
			x_c[k]    = x_s[k-1];
			rem_c[k]  = rem_s[k-1];
			root_c[k] = root_s[k-1];
		end
		for (int k = 0; k < SQ_STEPS; k++) begin
			r2_c[k]    = {rem_c[k], x_c[k][X_W-1 -: 2]};
			trial_c[k] = {2'b00, root_c[k], 2'b01};
			ge_c[k]    = r2_c[k] >= trial_c[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[SQ_STEPS-2:0], vin};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pass_s[0] <= pass_in;
			for (int k = 1; k < SQ_STEPS; k++) begin
				pass_s[k] <= pass_s[k-1];
			end
			for (int k = 0; k < SQ_STEPS; k++) begin
				x_s[k]    <= x_c[k] << 2;
				rem_s[k]  <= ge_c[k] ? (L_W+2)'(r2_c[k] - trial_c[k]) : (L_W+2)'(r2_c[k]);
				root_s[k] <= {root_c[k][L_W-2:0], ge_c[k]};
			end
		end
	end

	assign vout     = v_q[SQ_STEPS-1];
	assign root_out = root_s[SQ_STEPS-1];
	assign pass_out = pass_s[SQ_STEPS-1];

endmodule

`default_nettype wire

FILE: hw/rtl/bbn_div.sv
// Pipelined rounding divider, three lanes sharing one divisor, one quotient bit per stage.
// Depends on bbn_pkg.
`default_nettype none

module bbn_div (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               en,
	input  wire                               vin,
	input  wire [bbn_pkg::L_W-1:0]            len_in,
	input  bbn_pkg::sq_pass_t                 pass_in,
	output logic                              vout,
	output logic [2:0][bbn_pkg::QT_W-1:0]     quot_out,
	output bbn_pkg::tag_t                     tag_out
);
	import bbn_pkg::*;

	localparam int ST = QT_W + 1;

	logic [ST-1:0] v_q;
	logic [L_W-1:0]   len_s [ST];
	tag_t             tag_s [ST];
	logic [NUM_W-1:0] num_s [ST][3];
	logic [L_W-1:0]   rem_s [ST][3];
	logic [QT_W-1:0]  quo_s [ST][3];

	logic [NUM_W-1:0] num_c [3];
	logic [L_W:0]     r2_c  [QT_W][3];
	logic             ge_c  [QT_W][3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			num_c[j] = (NUM_W'(pass_in.an[j]) << NUM_SH) + NUM_W'(len_in >> 1);
		end
		for (int k = 0; k < QT_W; k++) begin
			for (int j = 0; j < 3; j++) begin
				r2_c[k][j] = {rem_s[k][j], num_s[k][j][QT_W-1-k]};
				ge_c[k][j] = r2_c[k][j] >= {1'b0, len_s[k]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[ST-2:0], vin};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			len_s[0] <= len_in;
			tag_s[0] <= pass_in.tag;
			for (int j = 0; j < 3; j++) begin
				num_s[0][j] <= num_c[j];
				rem_s[0][j] <= L_W'(num_c[j][NUM_W-1:QT_W]);
				quo_s[0][j] <= '0;
			end
			for (int k = 0; k < QT_W; k++) begin
				len_s[k+1] <= len_s[k];
				tag_s[k+1] <= tag_s[k];
				for (int j = 0; j < 3; j++) begin
					num_s[k+1][j] <= num_s[k][j];
					rem_s[k+1][j] <= ge_c[k][j] ? L_W'(r2_c[k][j] - {1'b0, len_s[k]})
						: L_W'(r2_c[k][j]);
					quo_s[k+1][j] <= {quo_s[k][j][QT_W-2:0], ge_c[k][j]};
				end
			end
		end
	end

	assign vout = v_q[ST-1];
	assign tag_out = tag_s[ST-1];
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			quot_out[j] = quo_s[ST-1][j];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/bevel_box_edge_normal.sv
// Top level of the bevelled box edge normal block: register file, pipeline and output skid.
// Depends on bbn_pkg, bbn_xform, bbn_shape, bbn_sqrt and bbn_div.
//
// Usage. Each input word carries a world point, the body translation and the three rows of
// the body rotation. The block turns the point into the body frame, checks it against the
// box shrunk by the bevel radius and, where two or more axes lie in the rounded zone, returns
// the unit surface normal in world coordinates with status one. A point on a face or inside
// gives status zero, and a vanishing offset gives status two; the normal is zero in both.
// Both channels use valid and ready. The pipeline takes one word in every cycle while the
// skid register is empty; most of its depth lies in the 31 square root stages and the 17
// divider stages, each resolving one bit but for the first divider stage, which loads the
// operands. When the receiver stalls, the pipeline keeps moving until a finished word finds
// the output register still full; that word goes into a one-word skid register and the
// whole pipeline then holds. Input ready is a register and does not wait on output ready:
// it is low exactly while the skid register holds a word. Reset clears all valid bits and
// sets the box corners and the bevel radius to zero. The box registers sit on the APB port;
// the user must write them only while no word is in flight; the block does not enforce it.
`default_nettype none

module bevel_box_edge_normal (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              psel,
	input  wire              penable,
	input  wire              pwrite,
	input  wire [4:0]        paddr,
	input  wire [31:0]       pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire              in_valid,
	output logic             in_ready,
	input  bbn_pkg::in_t     in_data,
	output logic             out_valid,
	input  wire              out_ready,
	output bbn_pkg::out_t    out_data
);
	import bbn_pkg::*;

	// Configuration registers.
	logic [2:0][31:0] box_lo_q, box_hi_q;
	logic [30:0]      bevel_q;
	logic             wr_c;

	assign pready = 1'b1;
	assign wr_c   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_lo_q <= '0;
			box_hi_q <= '0;
			bevel_q  <= '0;
		end else if (wr_c) begin
			case (paddr[4:2])
				REG_MIN_X: box_lo_q[0] <= pwdata;
				REG_MIN_Y: box_lo_q[1] <= pwdata;
				REG_MIN_Z: box_lo_q[2] <= pwdata;
				REG_MAX_X: box_hi_q[0] <= pwdata;
				REG_MAX_Y: box_hi_q[1] <= pwdata;
				REG_MAX_Z: box_hi_q[2] <= pwdata;
				REG_BEVEL: bevel_q     <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_MIN_X: prdata = box_lo_q[0];
			REG_MIN_Y: prdata = box_lo_q[1];
			REG_MIN_Z: prdata = box_lo_q[2];
			REG_MAX_X: prdata = box_hi_q[0];
			REG_MAX_Y: prdata = box_hi_q[1];
			REG_MAX_Z: prdata = box_hi_q[2];
			REG_BEVEL: prdata = {1'b0, bevel_q};
			default:   prdata = '0;
		endcase
	end

	// The pipeline moves as one whenever the skid register is empty.
	logic skid_valid_q;
	logic en;

	assign en       = !skid_valid_q;
	assign in_ready = en;

	logic                v_x, v_sh, v_sq, v_dv;
	logic [2:0][Q_W-1:0] q_x;
	tag_t                tag_x, tag_dv;
	logic [S_W-1:0]      sum_sh;
	sq_pass_t            pass_sh, pass_sq;
	logic [L_W-1:0]      len_sq;
	logic [2:0][QT_W-1:0] quot_dv;

	bbn_xform u_xform (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vin(in_valid), .din(in_data),
		.vout(v_x), .qout(q_x), .tag_out(tag_x)
	);

	bbn_shape u_shape (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vin(v_x), .qin(q_x), .tag_in(tag_x),
		.box_lo(box_lo_q), .box_hi(box_hi_q), .bevel(bevel_q),
		.vout(v_sh), .sum_out(sum_sh), .pass_out(pass_sh)
	);

	bbn_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vin(v_sh), .sum_in(sum_sh), .pass_in(pass_sh),
		.vout(v_sq), .root_out(len_sq), .pass_out(pass_sq)
	);

	bbn_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.vin(v_sq), .len_in(len_sq), .pass_in(pass_sq),
		.vout(v_dv), .quot_out(quot_dv), .tag_out(tag_dv)
	);

	// Clamp and sign the body frame normal, then rotate it back to world.
	logic [1:0] v_q;
	logic signed [U_W-1:0]  u_s1 [3];
	tag_t                   tag_s1, tag_s2;
	logic signed [UP_W-1:0] prod_s2 [3][3];
	logic [QT_W-1:0]        mag_c [3];
	logic signed [UACC_W-1:0] acc_c [3];
	logic signed [W_W-1:0]  w_c [3];
	logic signed [15:0]     n_c [3];
	out_t                   res_c;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			mag_c[j] = (quot_dv[j] > QT_W'(ONE)) ? QT_W'(ONE) : quot_dv[j];
		end
		for (int i = 0; i < 3; i++) begin
			acc_c[i] = UACC_W'(prod_s2[i][0]) + UACC_W'(prod_s2[i][1])
				+ UACC_W'(prod_s2[i][2]) + UACC_W'(1 << (ROT_FRAC_BITS - 1));
			w_c[i] = W_W'(acc_c[i] >>> ROT_FRAC_BITS);
			if (w_c[i] > ONE) begin
				n_c[i] = 16'(ONE);
			end else if (w_c[i] < -ONE) begin
				n_c[i] = -16'(ONE);
			end else begin
				n_c[i] = 16'(w_c[i]);
			end
			if (tag_s2.status != ST_VALID) begin
				n_c[i] = '0;
			end
		end
		res_c.status   = tag_s2.status;
		res_c.normal_x = n_c[0];
		res_c.normal_y = n_c[1];
		res_c.normal_z = n_c[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[0], v_dv};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				u_s1[j] <= tag_dv.neg[j] ? -U_W'(mag_c[j]) : U_W'(mag_c[j]);
			end
			tag_s1 <= tag_dv;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s2[i][j] <= UP_W'($signed(tag_s1.rm[i][j])) * UP_W'(u_s1[j]);
				end
			end
			tag_s2 <= tag_s1;
		end
	end

	// Output register with a one-word skid register behind it.
	logic push_c;
	out_t skid_q;

	assign push_c = en && v_q[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid    <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_ready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid || out_ready) begin
			out_valid <= push_c;
		end else if (push_c) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_ready) begin
				out_data <= skid_q;
			end
		end else if (!out_valid || out_ready) begin
			out_data <= res_c;
		end else if (push_c) begin
			skid_q <= res_c;
		end
	end

endmodule

`default_nettype wire
